[hdl/mtcs_pkg.sv]
package mtcs_pkg;

	localparam int NUM_STATES_DEF     = 256;
	localparam int MAX_SUCCESSORS_DEF = 16;
	localparam int COUNT_WIDTH_DEF    = 16;

	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_SAMPLE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  from_state;
		logic [7:0]  to_state;
		logic [31:0] random_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] next_state;
	} out_item_t;

	typedef enum logic [2:0] {
		FSM_CLR,
		FSM_IDLE,
		FSM_SCAN,
		FSM_DIV,
		FSM_WALK,
		FSM_DONE
	} fsm_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

[hdl/mtcs_div.sv]
module mtcs_div
	import mtcs_pkg::*;
#(
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [DW-1:0] divisor,
	output div_ctl_t      ctl,
	output logic [DW-1:0] remainder
);

	localparam int CW = $clog2(33);

	logic [31:0]   quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;

	assign shifted = {rem_q[DW-1:0], quo_q[31]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(32);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], 1'b0};
			rem_q <= diff[DW] ? shifted : diff;
		end
	end

	assign ctl.start  = start;
	assign ctl.busy   = busy_q;
	assign ctl.done   = done_q;
	assign remainder  = rem_q[DW-1:0];

endmodule

[hdl/mtcs_table.sv]
module mtcs_table
	import mtcs_pkg::*;
#(
	parameter int DEPTH = 4096,
	parameter int CW    = 16,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_index,
	input  logic [CW-1:0] wr_count,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_index,
	output logic [CW-1:0] rd_count
);

	logic [CW+7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {wr_index, wr_count};
		{rd_index, rd_count} <= mem[rd_addr];
	end

endmodule

[hdl/markov_transition_count_sampler.sv]
// Per-state successor table sampler. Each transfer returns one result. After reset the
// block clears its list lengths one state a cycle, so input stalls until all are cleared.
// An observe reads the state's list one entry a cycle through the table memory port and
// then updates the matching entry, appends a new one or reports the list full. A sample
// scans the list to sum the counts, runs a 32-step restoring remainder unit, then walks
// the list again. One item is in progress at a time; a finished result waits in the
// output register, so the next item can be accepted while it is stalled. Table entries
// need no clearing, since only entries below the list length are read.
module markov_transition_count_sampler
	import mtcs_pkg::*;
#(
	parameter int NUM_STATES     = NUM_STATES_DEF,
	parameter int MAX_SUCCESSORS = MAX_SUCCESSORS_DEF,
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int EW    = (MAX_SUCCESSORS > 1) ? $clog2(MAX_SUCCESSORS) : 1;
	localparam int LW    = $clog2(MAX_SUCCESSORS + 1);
	localparam int AW    = SW + EW;
	localparam int DEPTH = NUM_STATES * MAX_SUCCESSORS;
	localparam int TW    = COUNT_WIDTH + LW;
	localparam int DW    = (TW > 32) ? TW : 32;
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	fsm_t            state_q, state_d;
	in_item_t        item_q;
	logic [SW-1:0]   st_q;
	logic [SW-1:0]   clr_q;
	logic [LW-1:0]   len_q;
	logic [LW-1:0]   lens_mem [NUM_STATES];
	logic [LW-1:0]   rd_i_q;
	logic [LW-1:0]   chk_i_q;
	logic            chk_v_q;
	logic [DW-1:0]   acc_q;
	logic [DW-1:0]   pick_q;
	logic            hit_q;
	logic [LW-1:0]   hit_i_q;
	logic [COUNT_WIDTH-1:0] hit_c_q;
	logic            out_valid_q;
	out_item_t       res_q;
	out_item_t       out_q;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [7:0]      wr_index;
	logic [COUNT_WIDTH-1:0] wr_count;
	logic [AW-1:0]   rd_addr;
	logic [7:0]      rd_index;
	logic [COUNT_WIDTH-1:0] rd_count;
	logic            div_start;
	div_ctl_t        div_ctl;
	logic [DW-1:0]   rem;
	logic            accept;
	logic            len_wr;
	logic            done_go;
	logic [SW-1:0]   in_st;
	logic [DW-1:0]   run;

	function automatic logic [SW-1:0] state_of(logic [7:0] s);
		logic [7:0] r;
		r = s;
		for (int k = 7; k >= 0; k--) begin
			if ((NUM_STATES << k) <= 255) begin
				if (r >= 8'(NUM_STATES << k))
					r = r - 8'(NUM_STATES << k);
			end
		end
		return SW'(r);
	endfunction

	assign in_st    = state_of(in_data.from_state);
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != FSM_IDLE);
	assign run      = acc_q + DW'(rd_count);
	assign done_go  = !out_valid_q || !out_stall;
	assign len_wr   = wr_en && !hit_q && item_q.op == OP_OBSERVE;

	function automatic logic [AW-1:0] addr_of(logic [SW-1:0] s, logic [LW-1:0] i);
		logic [AW-1:0] a;
		a = AW'(s) * AW'(MAX_SUCCESSORS) + AW'(i);
		return a;
	endfunction

	mtcs_table #(.DEPTH(DEPTH), .CW(COUNT_WIDTH), .AW(AW)) u_table (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_index(wr_index),
		.wr_count(wr_count), .rd_addr(rd_addr), .rd_index(rd_index),
		.rd_count(rd_count)
	);

	mtcs_div #(.DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(item_q.random_value),
		.divisor(acc_q), .ctl(div_ctl), .remainder(rem)
	);

	assign rd_addr = addr_of(st_q, rd_i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_CLR;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLR)
				clr_q <= clr_q + SW'(1);
			if (state_q == FSM_DONE && done_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_CLR)
			lens_mem[clr_q] <= '0;
		else if (len_wr)
			lens_mem[st_q] <= len_q + LW'(1);
		if (accept)
			len_q <= lens_mem[in_st];
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = addr_of(st_q, hit_q ? hit_i_q : len_q);
		wr_index  = item_q.to_state;
		wr_count  = hit_q ? ((hit_c_q == CMAX) ? hit_c_q : hit_c_q + COUNT_WIDTH'(1))
		                  : COUNT_WIDTH'(1);
		unique case (state_q)
			FSM_CLR:  if (clr_q == SW'(NUM_STATES - 1)) state_d = FSM_IDLE;
			FSM_IDLE: if (accept) state_d = FSM_SCAN;
			FSM_SCAN: begin
				if (rd_i_q >= len_q && !chk_v_q) begin
					if (item_q.op == OP_OBSERVE) begin
						wr_en   = hit_q || (len_q < LW'(MAX_SUCCESSORS));
						state_d = FSM_DONE;
					end else if (len_q == '0 || acc_q == '0) begin
						state_d = FSM_DONE;
					end else begin
						div_start = 1'b1;
						state_d   = FSM_DIV;
					end
				end else if (item_q.op == OP_OBSERVE && hit_q) begin
					wr_en   = 1'b1;
					state_d = FSM_DONE;
				end
			end
			FSM_DIV:  if (div_ctl.done) state_d = FSM_WALK;
			FSM_WALK: if (chk_v_q && (pick_q < run || chk_i_q == len_q - LW'(1)))
				state_d = FSM_DONE;
			FSM_DONE: if (done_go) state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		chk_v_q <= 1'b0;
		unique case (state_q)
			FSM_CLR: ;
			FSM_IDLE: begin
				if (accept) begin
					item_q  <= in_data;
					st_q    <= in_st;
					rd_i_q  <= '0;
					acc_q   <= '0;
					hit_q   <= 1'b0;
					res_q   <= '0;
				end
			end
			FSM_SCAN: begin
				if (rd_i_q < len_q && !(item_q.op == OP_OBSERVE && hit_q)) begin
					rd_i_q  <= rd_i_q + LW'(1);
					chk_v_q <= 1'b1;
					chk_i_q <= rd_i_q;
				end
				if (chk_v_q) begin
					acc_q <= run;
					if (item_q.op == OP_OBSERVE && rd_index == item_q.to_state && !hit_q) begin
						hit_q   <= 1'b1;
						hit_i_q <= chk_i_q;
						hit_c_q <= rd_count;
					end
				end
				if (rd_i_q >= len_q && !chk_v_q) begin
					if (item_q.op == OP_OBSERVE) begin
						if (!hit_q && len_q >= LW'(MAX_SUCCESSORS))
							res_q.status <= ST_FULL;
					end else if (len_q == '0 || acc_q == '0) begin
						res_q.status <= ST_EMPTY;
					end
				end
			end
			FSM_DIV: begin
				rd_i_q <= '0;
				acc_q  <= '0;
				if (div_ctl.done)
					pick_q <= rem;
			end
			FSM_WALK: begin
				if (rd_i_q < len_q) begin
					rd_i_q  <= rd_i_q + LW'(1);
					chk_v_q <= 1'b1;
					chk_i_q <= rd_i_q;
				end
				if (chk_v_q) begin
					acc_q <= run;
					if (pick_q < run || chk_i_q == len_q - LW'(1)) begin
						res_q.next_state <= rd_index;
						rd_i_q           <= len_q;
						chk_v_q          <= 1'b0;
					end
				end
			end
			FSM_DONE: begin
				if (done_go)
					out_q <= res_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != FSM_IDLE) |-> !accept) else $error("accept while busy");
	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_DONE) |=> out_valid) else $error("result lost");
	a_div_only_sample: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (item_q.op == OP_SAMPLE && acc_q != '0)) else $error("bad divide");
	a_write_only_observe: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (item_q.op == OP_OBSERVE)) else $error("sample wrote table");
`endif

endmodule
